// ===== rtl/core/flbc_pkg.sv =====
// ----------------------------------------------------------------------------
// flbc_pkg
// shared types, codes and constants of the frame load bottleneck classifier
// ----------------------------------------------------------------------------
package flbc_pkg;

  localparam int MAX_STREAMS = 8;
  localparam int AVG_W = 24;
  localparam int DVD_W = 40;
  localparam int CNT_W = 16;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_FAST_WEIGHT = 3'd1;
  localparam logic [2:0] REG_SLOW_WEIGHT = 3'd2;
  localparam logic [2:0] REG_BOUND_THR = 3'd3;
  localparam logic [2:0] REG_UTIL_THR = 3'd4;
  localparam logic [2:0] REG_IDLE_THR = 3'd5;
  localparam logic [2:0] REG_WARMUP = 3'd6;

  localparam logic [2:0] VERDICT_INSUFFICIENT = 3'd0;
  localparam logic [2:0] VERDICT_CPU_BOUND = 3'd1;
  localparam logic [2:0] VERDICT_GPU_UNDERUSED = 3'd2;
  localparam logic [2:0] VERDICT_GPU_BOUND = 3'd3;
  localparam logic [2:0] VERDICT_BALANCED = 3'd4;

  localparam logic [15:0] CONF_BALANCED = 16'd52429;

  // average select
  localparam logic [1:0] SEL_CPU = 2'd0;
  localparam logic [1:0] SEL_GPU = 2'd1;
  localparam logic [1:0] SEL_FRAME = 2'd2;
  localparam logic [1:0] SEL_UTIL = 2'd3;

  // divide select
  localparam logic [1:0] DIV_CPU_SHARE = 2'd0;
  localparam logic [1:0] DIV_GPU_SHARE = 2'd1;
  localparam logic [1:0] DIV_CPU_STREAMS = 2'd2;

  typedef struct packed {
    logic [15:0] cpu_time;
    logic [15:0] gpu_time;
    logic [15:0] frame_time;
    logic [15:0] gpu_util;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [3:0]  stream_count;
    logic        inject_compute;
    logic [15:0] confidence;
    logic [15:0] cpu_share;
    logic [15:0] gpu_share;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] fast_weight;
    logic [15:0] slow_weight;
    logic [15:0] bound_threshold;
    logic [15:0] util_threshold;
    logic [15:0] idle_share_threshold;
    logic [7:0]  warmup_frames;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       ema_step;
    logic [1:0] ema_sel;
    logic       div_start;
    logic       div_capture;
    logic [1:0] div_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// ===== rtl/core/frame_load_bottleneck_classifier.sv =====
// ----------------------------------------------------------------------------
// frame_load_bottleneck_classifier
// per-frame load averages and cpu/gpu bottleneck verdict
// ----------------------------------------------------------------------------
// steps from accept to out_valid: four average updates, three 40-bit divides
//   on one shared restoring divider, then the load of the result register
// accept: a new item is taken only after the last result is loaded; a stalled
//   result holds the next item in its final step
// reset: synchronous active-low; registers return to defaults, averages clear
module frame_load_bottleneck_classifier (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  flbc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output flbc_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  flbc_pkg::cfg_t    cfg_r;
  flbc_pkg::cmd_t    cmd;
  flbc_pkg::status_t status;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b1;
      cfg_r.fast_weight <= 16'd13107;
      cfg_r.slow_weight <= 16'd3277;
      cfg_r.bound_threshold <= 16'd49152;
      cfg_r.util_threshold <= 16'd36045;
      cfg_r.idle_share_threshold <= 16'd32768;
      cfg_r.warmup_frames <= 8'd10;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        flbc_pkg::REG_ENABLE:      cfg_r.enable <= cfg_wdata[0];
        flbc_pkg::REG_FAST_WEIGHT: cfg_r.fast_weight <= cfg_wdata;
        flbc_pkg::REG_SLOW_WEIGHT: cfg_r.slow_weight <= cfg_wdata;
        flbc_pkg::REG_BOUND_THR:   cfg_r.bound_threshold <= cfg_wdata;
        flbc_pkg::REG_UTIL_THR:    cfg_r.util_threshold <= cfg_wdata;
        flbc_pkg::REG_IDLE_THR:    cfg_r.idle_share_threshold <= cfg_wdata;
        flbc_pkg::REG_WARMUP:      cfg_r.warmup_frames <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  flbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // averages, divider, verdict and output register
  flbc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/flbc_divider.sv =====
// ----------------------------------------------------------------------------
// flbc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module flbc_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [flbc_pkg::DVD_W-1:0]      dividend,
  input  logic [flbc_pkg::AVG_W-1:0]      divisor,
  output logic                            done,
  output logic [flbc_pkg::DVD_W-1:0]      quotient,
  output logic                            rem_nz
);

  localparam int STEP_W = $clog2(flbc_pkg::DVD_W);

  logic [flbc_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [flbc_pkg::AVG_W-1:0] rem_r, rem_nxt;
  logic [flbc_pkg::AVG_W-1:0] dsr_r, dsr_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [flbc_pkg::AVG_W:0]   rem_sh;
  logic [flbc_pkg::AVG_W:0]   rem_sub;

  always_comb begin
    rem_sh = {rem_r, q_r[flbc_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub[flbc_pkg::AVG_W-1:0];
        q_nxt = {q_r[flbc_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[flbc_pkg::AVG_W-1:0];
        q_nxt = {q_r[flbc_pkg::DVD_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(flbc_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quotient = q_r;
  assign rem_nz = |rem_r;

endmodule

// ===== rtl/core/flbc_datapath.sv =====
// ----------------------------------------------------------------------------
// flbc_datapath
// frame counter, averages, shared divider and verdict logic
// ----------------------------------------------------------------------------
module flbc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  flbc_pkg::cfg_t       cfg,
  input  flbc_pkg::cmd_t       cmd,
  output flbc_pkg::status_t    status,
  input  flbc_pkg::in_item_t   in_data,
  output flbc_pkg::out_item_t  out_data
);

  localparam int AW = flbc_pkg::AVG_W;
  localparam int DW = flbc_pkg::DVD_W;

  flbc_pkg::in_item_t  in_r;
  flbc_pkg::out_item_t out_r, out_nxt;
  logic [flbc_pkg::CNT_W-1:0] frames_r, frames_nxt;
  logic [AW-1:0] cpu_avg_r, gpu_avg_r, frame_avg_r, util_avg_r;
  logic [AW-1:0] ema_new;
  logic [AW-1:0] ema_avg, ema_x;
  logic [15:0]   ema_alpha;
  logic signed [AW+1:0]  ema_diff;
  logic signed [AW+18:0] ema_prod;
  logic signed [AW+18:0] ema_rnd;
  logic [DW-1:0] qc_r, qg_r, q6_r;
  logic          rc_nz_r, rg_nz_r;
  logic [AW-1:0] divisor;
  logic [DW-1:0] dividend;
  logic          div_done, div_rem_nz;
  logic [DW-1:0] div_q;
  logic          warm, cpu_bound, gpu_bound, gpu_idle;
  logic [AW:0]   idle;
  logic [AW+3:0] idle_x6;
  logic [3:0]    idle_streams;

  function automatic logic [15:0] sat16(input logic [DW-1:0] v);
    sat16 = (v > DW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // ema operand select
  always_comb begin
    case (cmd.ema_sel)
      flbc_pkg::SEL_CPU: begin
        ema_avg = cpu_avg_r; ema_x = {in_r.cpu_time, 8'd0}; ema_alpha = cfg.fast_weight;
      end
      flbc_pkg::SEL_GPU: begin
        ema_avg = gpu_avg_r; ema_x = {in_r.gpu_time, 8'd0}; ema_alpha = cfg.fast_weight;
      end
      flbc_pkg::SEL_FRAME: begin
        ema_avg = frame_avg_r; ema_x = {in_r.frame_time, 8'd0};
        ema_alpha = cfg.fast_weight;
      end
      default: begin
        ema_avg = util_avg_r; ema_x = {in_r.gpu_util, 8'd0}; ema_alpha = cfg.slow_weight;
      end
    endcase
    // avg + round(alpha * (x - avg) / 2^16), or x itself on the first frame
    ema_diff = $signed({2'b00, ema_x}) - $signed({2'b00, ema_avg});
    ema_prod = $signed({1'b0, ema_alpha}) * ema_diff;
    ema_rnd = (ema_prod + (AW+19)'(32768)) >>> 16;
    if (frames_r == flbc_pkg::CNT_W'(1))
      ema_new = ema_x;
    else
      ema_new = ema_avg + ema_rnd[AW-1:0];
  end

  always_comb begin
    frames_nxt = frames_r;
    if (cmd.load_in && cfg.enable && (frames_r != {flbc_pkg::CNT_W{1'b1}}))
      frames_nxt = frames_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
      cpu_avg_r <= '0;
      gpu_avg_r <= '0;
      frame_avg_r <= '0;
      util_avg_r <= '0;
    end else begin
      frames_r <= frames_nxt;
      if (cmd.ema_step && cfg.enable) begin
        case (cmd.ema_sel)
          flbc_pkg::SEL_CPU:   cpu_avg_r <= ema_new;
          flbc_pkg::SEL_GPU:   gpu_avg_r <= ema_new;
          flbc_pkg::SEL_FRAME: frame_avg_r <= ema_new;
          default:             util_avg_r <= ema_new;
        endcase
      end
    end
  end

  // divider operands
  assign divisor = (frame_avg_r == '0) ? AW'(1) : frame_avg_r;

  always_comb begin
    case (cmd.div_sel)
      flbc_pkg::DIV_CPU_SHARE: dividend = {cpu_avg_r, 16'd0};
      flbc_pkg::DIV_GPU_SHARE: dividend = {gpu_avg_r, 16'd0};
      default:                 dividend = DW'({cpu_avg_r, 2'b00}) + DW'({cpu_avg_r, 1'b0});
    endcase
  end

  flbc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rem_nz)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        flbc_pkg::DIV_CPU_SHARE: begin qc_r <= div_q; rc_nz_r <= div_rem_nz; end
        flbc_pkg::DIV_GPU_SHARE: begin qg_r <= div_q; rg_nz_r <= div_rem_nz; end
        default:                 q6_r <= div_q;
      endcase
    end
    if (cmd.load_out) out_r <= out_nxt;
  end

  // verdict
  always_comb begin
    warm = frames_r >= flbc_pkg::CNT_W'(cfg.warmup_frames);
    cpu_bound = (qc_r > DW'(cfg.bound_threshold)) ||
                ((qc_r == DW'(cfg.bound_threshold)) && rc_nz_r);
    gpu_bound = (qg_r > DW'(cfg.bound_threshold)) ||
                ((qg_r == DW'(cfg.bound_threshold)) && rg_nz_r);
    gpu_idle = (util_avg_r < {cfg.util_threshold, 8'd0}) &&
               (qg_r < DW'(cfg.idle_share_threshold));
    idle = (AW+1)'(1 << AW) - {1'b0, util_avg_r};
    idle_x6 = {1'b0, idle, 2'b00} + {2'b00, idle, 1'b0};
    idle_streams = idle_x6[AW+3:AW];
    if (idle_streams < 4'd3) idle_streams = 4'd3;
    if (idle_streams > 4'(flbc_pkg::MAX_STREAMS)) idle_streams = 4'(flbc_pkg::MAX_STREAMS);

    out_nxt.cpu_share = sat16(qc_r >> 2);
    out_nxt.gpu_share = sat16(qg_r >> 2);
    out_nxt.verdict = flbc_pkg::VERDICT_INSUFFICIENT;
    out_nxt.stream_count = 4'd0;
    out_nxt.inject_compute = 1'b0;
    out_nxt.confidence = 16'd0;
    if (warm) begin
      if (cpu_bound) begin
        out_nxt.verdict = flbc_pkg::VERDICT_CPU_BOUND;
        if (q6_r < DW'(2))
          out_nxt.stream_count = 4'd2;
        else if (q6_r > DW'(flbc_pkg::MAX_STREAMS))
          out_nxt.stream_count = 4'(flbc_pkg::MAX_STREAMS);
        else
          out_nxt.stream_count = q6_r[3:0];
        out_nxt.confidence = sat16(qc_r);
      end else if (gpu_idle) begin
        out_nxt.verdict = flbc_pkg::VERDICT_GPU_UNDERUSED;
        out_nxt.stream_count = idle_streams;
        out_nxt.inject_compute = 1'b1;
        out_nxt.confidence = sat16(DW'(idle >> 8));
      end else if (gpu_bound) begin
        out_nxt.verdict = flbc_pkg::VERDICT_GPU_BOUND;
        out_nxt.stream_count = 4'd2;
        out_nxt.confidence = sat16(qg_r);
      end else begin
        out_nxt.verdict = flbc_pkg::VERDICT_BALANCED;
        out_nxt.stream_count = 4'd3;
        out_nxt.confidence = flbc_pkg::CONF_BALANCED;
      end
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/flbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// flbc_ctrl
// sequencer: average updates, three divides, result hand-off
// ----------------------------------------------------------------------------
module flbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  flbc_pkg::status_t  status,
  output flbc_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMA = 3'd1;
  localparam logic [2:0] S_DIV_GO = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.ema_sel = cnt_r;
    cmd.div_sel = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_EMA;
        end
      end
      S_EMA: begin
        cmd.ema_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == flbc_pkg::SEL_UTIL) begin
          cnt_nxt = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_DIV_GO;
          if (cnt_r == flbc_pkg::DIV_CPU_STREAMS) begin
            cnt_nxt = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken result");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == S_DIV_WAIT))
    else $error("divide finished outside wait state");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EMA && cnt_r == 2'd0))
    else $error("accepted item did not start average update");
`endif

endmodule

// ===== tb/tb_frame_load_bottleneck_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_load_bottleneck_classifier
// self-checking bench: directed and random frames, several register settings,
// results compared in order against an in-bench model of the averaging and
// verdict logic
// ----------------------------------------------------------------------------
module tb_frame_load_bottleneck_classifier;

  // model of the classifier, plus the queue of verdicts still owed
  class verdict_board;
    bit         en;
    bit [15:0]  s_alpha, l_alpha, bound_thr, util_thr, idle_thr;
    bit [7:0]   warmup;
    bit [15:0]  frames;
    bit [23:0]  cpu_avg, gpu_avg, frm_avg, util_avg;
    flbc_pkg::out_item_t  owed[$];
    int         errors;
    int         checked;

    function new();
      en = 1; s_alpha = 13107; l_alpha = 3277; bound_thr = 49152;
      util_thr = 36045; idle_thr = 32768; warmup = 10;
      frames = 0; cpu_avg = 0; gpu_avg = 0; frm_avg = 0; util_avg = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        flbc_pkg::REG_ENABLE:      en = v[0];
        flbc_pkg::REG_FAST_WEIGHT: s_alpha = v;
        flbc_pkg::REG_SLOW_WEIGHT: l_alpha = v;
        flbc_pkg::REG_BOUND_THR:   bound_thr = v;
        flbc_pkg::REG_UTIL_THR:    util_thr = v;
        flbc_pkg::REG_IDLE_THR:    idle_thr = v;
        flbc_pkg::REG_WARMUP:      warmup = v[7:0];
        default: ;
      endcase
    endfunction

    function bit [23:0] blend(bit [23:0] avg, bit [23:0] x, bit [15:0] a);
      bit [63:0] t;
      t = (64'(a) * x + (64'd65536 - a) * avg + 64'd32768) >> 16;
      return t[23:0];
    endfunction

    function bit [15:0] sat(bit [63:0] v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function bit [3:0] clip(bit [63:0] v, int lo);
      if (v < 64'(lo)) return 4'(lo);
      if (v > 64'(flbc_pkg::MAX_STREAMS)) return 4'(flbc_pkg::MAX_STREAMS);
      return v[3:0];
    endfunction

    // account for one accepted frame
    function void note_frame(flbc_pkg::in_item_t f);
      bit [63:0] dv, idle;
      flbc_pkg::out_item_t r;
      if (en) begin
        if (frames != 16'hFFFF) frames++;
        if (frames == 1) begin
          cpu_avg = {f.cpu_time, 8'h0}; gpu_avg = {f.gpu_time, 8'h0};
          frm_avg = {f.frame_time, 8'h0}; util_avg = {f.gpu_util, 8'h0};
        end else begin
          cpu_avg = blend(cpu_avg, {f.cpu_time, 8'h0}, s_alpha);
          gpu_avg = blend(gpu_avg, {f.gpu_time, 8'h0}, s_alpha);
          frm_avg = blend(frm_avg, {f.frame_time, 8'h0}, s_alpha);
          util_avg = blend(util_avg, {f.gpu_util, 8'h0}, l_alpha);
        end
      end
      dv = (frm_avg != 0) ? 64'(frm_avg) : 64'd1;
      r = '0;
      if (frames >= 16'(warmup)) begin
        if (64'(cpu_avg) * 65536 > 64'(bound_thr) * dv) begin
          r.verdict = flbc_pkg::VERDICT_CPU_BOUND;
          r.stream_count = clip(64'(cpu_avg) * 6 / dv, 2);
          r.confidence = sat(64'(cpu_avg) * 65536 / dv);
        end else if (64'(util_avg) < (64'(util_thr) << 8) &&
                     64'(gpu_avg) * 65536 < 64'(idle_thr) * dv) begin
          idle = (64'd1 << 24) - util_avg;
          r.verdict = flbc_pkg::VERDICT_GPU_UNDERUSED;
          r.stream_count = clip((idle * 6) >> 24, 3);
          r.inject_compute = 1'b1;
          r.confidence = sat(idle >> 8);
        end else if (64'(gpu_avg) * 65536 > 64'(bound_thr) * dv) begin
          r.verdict = flbc_pkg::VERDICT_GPU_BOUND;
          r.stream_count = 4'd2;
          r.confidence = sat(64'(gpu_avg) * 65536 / dv);
        end else begin
          r.verdict = flbc_pkg::VERDICT_BALANCED;
          r.stream_count = 4'd3;
          r.confidence = flbc_pkg::CONF_BALANCED;
        end
      end
      r.cpu_share = sat(64'(cpu_avg) * 16384 / dv);
      r.gpu_share = sat(64'(gpu_avg) * 16384 / dv);
      owed.push_back(r);
    endfunction

    function void check_verdict(flbc_pkg::out_item_t got);
      flbc_pkg::out_item_t e;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      e = owed.pop_front();
      if (got.verdict !== e.verdict) begin
        errors++;
        $display("%0t: verdict exp %0d got %0d", $time, e.verdict, got.verdict);
      end
      if (got.stream_count !== e.stream_count) begin
        errors++;
        $display("%0t: stream_count exp %0d got %0d", $time, e.stream_count,
                 got.stream_count);
      end
      if (got.inject_compute !== e.inject_compute) begin
        errors++;
        $display("%0t: inject_compute exp %0d got %0d", $time, e.inject_compute,
                 got.inject_compute);
      end
      if (got.confidence !== e.confidence) begin
        errors++;
        $display("%0t: confidence exp %0d got %0d", $time, e.confidence,
                 got.confidence);
      end
      if (got.cpu_share !== e.cpu_share) begin
        errors++;
        $display("%0t: cpu_share exp %0d got %0d", $time, e.cpu_share, got.cpu_share);
      end
      if (got.gpu_share !== e.gpu_share) begin
        errors++;
        $display("%0t: gpu_share exp %0d got %0d", $time, e.gpu_share, got.gpu_share);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  flbc_pkg::in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  flbc_pkg::out_item_t   out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  verdict_board board;
  int          frames_sent;
  bit          hold_rx;     // requests a long receiver hold-off
  int          sel_mix;     // random stimulus style of the current phase

  frame_load_bottleneck_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // limit: ~1200 frames plus random waits on each side, with margin to spare
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.write_reg(idx, v);
  endtask

  // send one frame after a random gap; valid stays up across back-to-back items
  task automatic send_frame(flbc_pkg::in_item_t f, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_frame(f);
    frames_sent++;
  endtask

  task automatic drain_idle();
    in_valid <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    // block holds nothing once its last result is out, small margin anyway
    repeat (20) @(posedge clk);
  endtask

  function automatic flbc_pkg::in_item_t rand_frame();
    flbc_pkg::in_item_t f;
    int ft;
    case (sel_mix)
      0: begin
        f = {$urandom, $urandom};
      end
      default: begin
        // realistic frame: parts no larger than the whole unless frame time is forced to zero, varied bias
        ft = $urandom_range(1, 65535);
        f.frame_time = 16'(ft);
        f.cpu_time = 16'($urandom_range(0, ft));
        f.gpu_time = 16'($urandom_range(0, ft));
        f.gpu_util = 16'($urandom);
        if ($urandom_range(0, 3) == 0) f.cpu_time = 16'($urandom_range(ft * 3 / 4, ft));
        if ($urandom_range(0, 3) == 0) f.gpu_time = 16'($urandom_range(0, ft / 3));
        if ($urandom_range(0, 5) == 0) f.frame_time = 16'd0;
      end
    endcase
    return f;
  endfunction

  // receiver: random wait before each item, plus one long hold-off on request
  initial begin
    int rx_wait;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_rx = 0;
      end
      rx_wait = $urandom_range(0, 9);
      if (rx_wait != 0) begin
        out_stall <= 1'b1;
        repeat (rx_wait) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_verdict(out_data);
    end
  end

  initial begin
    flbc_pkg::in_item_t f;
    bit [15:0] xs[4];
    board = new();
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_wr_en = 0; cfg_index = flbc_pkg::REG_ENABLE; cfg_wdata = '0;
    frames_sent = 0; hold_rx = 0; sel_mix = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, zero frame time, warmup crossing
    xs = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
    for (int i = 0; i < 12; i++) begin
      f.cpu_time = xs[i % 4]; f.gpu_time = xs[(i + 1) % 4];
      f.frame_time = xs[(i / 4 + 2) % 4]; f.gpu_util = xs[(i + 3) % 4];
      send_frame(f);
    end
    f = '{16'h0800, 16'h0100, 16'h0A00, 16'h1000}; send_frame(f); // cpu bound
    f = '{16'h0200, 16'h0200, 16'h0A00, 16'h1000}; send_frame(f); // underused
    f = '{16'h0100, 16'h0A00, 16'h0A00, 16'hFF00}; send_frame(f); // gpu bound
    f = '{16'h0500, 16'h0600, 16'h0A00, 16'hF000}; send_frame(f); // balanced
    drain_idle();
    // disabled: state frozen, results still produced
    cfg_write(flbc_pkg::REG_ENABLE, 16'h0000);
    f = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000}; send_frame(f);
    f = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}; send_frame(f);
    drain_idle();
    cfg_write(flbc_pkg::REG_ENABLE, 16'h0001);

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(flbc_pkg::REG_FAST_WEIGHT, 16'hFFFF);
          cfg_write(flbc_pkg::REG_SLOW_WEIGHT, 16'h0000);
          cfg_write(flbc_pkg::REG_WARMUP, 16'd1);
        end
        1: begin
          cfg_write(flbc_pkg::REG_FAST_WEIGHT, 16'h0000);
          cfg_write(flbc_pkg::REG_SLOW_WEIGHT, 16'hFFFF);
          cfg_write(flbc_pkg::REG_BOUND_THR, 16'h0000);
          cfg_write(flbc_pkg::REG_WARMUP, 16'd255);
        end
        2: begin
          cfg_write(flbc_pkg::REG_BOUND_THR, 16'hFFFF);
          cfg_write(flbc_pkg::REG_UTIL_THR, 16'hFFFF);
          cfg_write(flbc_pkg::REG_IDLE_THR, 16'hFFFF);
          cfg_write(flbc_pkg::REG_WARMUP, 16'd3);
        end
        3: begin
          cfg_write(flbc_pkg::REG_UTIL_THR, 16'h0000);
          cfg_write(flbc_pkg::REG_IDLE_THR, 16'h0000);
          cfg_write(flbc_pkg::REG_FAST_WEIGHT, 16'd13107);
          cfg_write(flbc_pkg::REG_SLOW_WEIGHT, 16'd3277);
        end
        default: begin
          for (int r = 1; r <= 5; r++) cfg_write(r[2:0], 16'($urandom));
          cfg_write(flbc_pkg::REG_WARMUP, 16'($urandom_range(1, 20)));
          cfg_write(flbc_pkg::REG_ENABLE, 16'($urandom_range(0, 5) != 0));
        end
      endcase
      sel_mix = (ph == 7) ? 0 : ($urandom_range(0, 4) != 0);
      if (ph == 2) hold_rx = 1;   // long receiver hold-off, sender keeps offering
      for (int i = 0; i < 150; i++) begin
        f = rand_frame();
        send_frame(f, (ph != 2) && ($urandom_range(0, 3) != 0));
        // in phase 4 the sender pauses once until all owed verdicts are back
        if (ph == 4 && i == 60) begin
          in_valid <= 0;
          while (board.owed.size() != 0) @(posedge clk);
        end
      end
      drain_idle();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d frames over 8 register settings, incl. disabled and warmup",
             frames_sent);
    $display("extremes, %0d verdicts checked", board.checked);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== frame_load_bottleneck_classifier.f =====
rtl/core/flbc_pkg.sv
rtl/core/flbc_divider.sv
rtl/core/flbc_datapath.sv
rtl/core/flbc_ctrl.sv
rtl/core/frame_load_bottleneck_classifier.sv
tb/tb_frame_load_bottleneck_classifier.sv
